>>> hdl/cvr_pkg.sv
// Shared constants, types and the CORDIC arctangent table for the velocity rotator.
package cvr_pkg;

    // CORDIC layout
    localparam int CORDIC_ITERS = 16;
    localparam int GUARD_BITS   = 8;
    localparam int Z_W          = 32;
    localparam int XY_EXTRA     = 11;   // guard bits plus headroom for quadrant and gain growth

    // Pipeline: front stage, one cell per iteration, multiply stage, output register
    localparam int NUM_STAGES   = CORDIC_ITERS + 3;

    // Gain correction, Q1.22, and the rounding shift back to Q3.12
    localparam int                 GAIN_W      = 23;
    localparam logic signed [22:0] GAIN_Q22    = 23'sd2547003;
    localparam int                 ROUND_SHIFT = 30;

    // Configuration port
    localparam int               CFG_IDX_W       = 8;
    localparam int               CFG_DATA_W      = 16;
    localparam logic [7:0]       REG_ZERO_OFFSET = 8'd0;
    localparam logic [7:0]       REG_DRIVE_MODE  = 8'd1;
    localparam logic [1:0]       MODE_RESERVED   = 2'd3;

    typedef enum logic [1:0] {
        MODE_GIMBAL_FOLLOW  = 2'd0,
        MODE_GIMBAL_LOCK    = 2'd1,
        MODE_CHASSIS_FOLLOW = 2'd2
    } t_drive_mode;

    // atan(2^-i) in binary angle units, 2^32 per turn
    function automatic logic signed [Z_W-1:0] atan_entry(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:       v = 32'sd536870912;
            1:       v = 32'sd316933406;
            2:       v = 32'sd167458907;
            3:       v = 32'sd85004756;
            4:       v = 32'sd42667331;
            5:       v = 32'sd21354465;
            6:       v = 32'sd10679838;
            7:       v = 32'sd5340245;
            8:       v = 32'sd2670163;
            9:       v = 32'sd1335087;
            10:      v = 32'sd667544;
            11:      v = 32'sd333772;
            12:      v = 32'sd166886;
            13:      v = 32'sd83443;
            14:      v = 32'sd41722;
            15:      v = 32'sd20861;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/cvr_cordic_cell.sv
// One CORDIC rotation cell: a single micro-rotation with its own pipeline register.
module cvr_cordic_cell #(
    parameter int XW    = 27,
    parameter int PW    = 33,
    parameter int STAGE = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [XW-1:0]          i_x,
    input  logic signed [XW-1:0]          i_y,
    input  logic signed [cvr_pkg::Z_W-1:0] i_z,
    input  logic [PW-1:0]                 i_pass,
    output logic                          o_valid,
    output logic signed [XW-1:0]          o_x,
    output logic signed [XW-1:0]          o_y,
    output logic signed [cvr_pkg::Z_W-1:0] o_z,
    output logic [PW-1:0]                 o_pass
);

    localparam logic signed [cvr_pkg::Z_W-1:0] ATAN = cvr_pkg::atan_entry(STAGE);

    logic                          r_valid;
    logic signed [XW-1:0]          r_x, r_y;
    logic signed [cvr_pkg::Z_W-1:0] r_z;
    logic [PW-1:0]                 r_pass;

    logic signed [XW-1:0]          n_x, n_y;
    logic signed [cvr_pkg::Z_W-1:0] n_z;
    logic signed [XW-1:0]          w_xs, w_ys;

    // micro-rotation, direction from the sign of the residual angle
    always_comb begin
        w_xs = i_x >>> STAGE;
        w_ys = i_y >>> STAGE;
        if (!i_z[cvr_pkg::Z_W-1]) begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - ATAN;
        end else begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + ATAN;
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_pass <= i_pass;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_pass  = r_pass;

endmodule

>>> hdl/cvr_gain_mult.sv
// Gain correction stage: scales the CORDIC outputs by the Q1.22 gain constant.
module cvr_gain_mult #(
    parameter int XW  = 27,
    parameter int PW  = 33,
    parameter int PRW = 50
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  logic [PW-1:0]        i_pass,
    output logic                 o_valid,
    output logic signed [PRW-1:0] o_px,
    output logic signed [PRW-1:0] o_py,
    output logic [PW-1:0]        o_pass
);

    logic                  r_valid;
    logic signed [PRW-1:0] r_px, r_py;
    logic [PW-1:0]         r_pass;

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // two constant multiplies, registered
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px   <= PRW'(i_x) * PRW'(cvr_pkg::GAIN_Q22);
            r_py   <= PRW'(i_y) * PRW'(cvr_pkg::GAIN_Q22);
            r_pass <= i_pass;
        end
    end

    assign o_valid = r_valid;
    assign o_px    = r_px;
    assign o_py    = r_py;
    assign o_pass  = r_pass;

endmodule

>>> hdl/chassis_velocity_rotator_unit.sv
// Top level of the chassis velocity rotator: front stage, CORDIC cell chain, gain multiply, output stage.
//
// Usage:
//   Input stream (s_axis): one word per control tick holding gimbal_angle,
//   vel_x, vel_y and yaw_rate. Output stream (m_axis): one word per input
//   word holding the rotated chassis velocity, the pass-through yaw rate and
//   the relative-rate target; tuser carries the saturated flag.
//   Config channel: index 0 writes zero_offset, index 1 writes drive_mode
//   (a mode value of 3 is dropped); other indexes are ignored. The channel
//   is always ready. Write it only while no word is in flight.
//   Path from input acceptance to output valid: front stage, 16 CORDIC
//   cells, gain multiply, output register.
//   Throughput: one word per cycle while the receiver does not stall, set
//   by the cell chain where each cell performs one micro-rotation per cycle.
//   Reset clears all valid bits, zero_offset and drive_mode (gimbal follow).
//   When the receiver stalls, words pack up into empty stages; tready on
//   the input falls only once every stage holds a word.
module chassis_velocity_rotator_unit #(
    parameter int ANGLE_BITS = 16,
    parameter int VEL_BITS   = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // input stream
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // tdata, low bit up: gimbal_angle, vel_x, vel_y, yaw_rate, zero pad
    input  logic [((ANGLE_BITS + 3 * VEL_BITS + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    // output stream
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // tdata, low bit up: chassis_vel_x, chassis_vel_y, yaw_rate_out,
    // relative_rate_target, zero pad
    output logic [((4 * VEL_BITS + 7) / 8) * 8 - 1:0] o_m_axis_tdata,
    // tuser: saturated
    output logic o_m_axis_tuser,
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cvr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cvr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int OUT_TDW = ((4 * VEL_BITS + 7) / 8) * 8;
    localparam int XW      = VEL_BITS + cvr_pkg::XY_EXTRA;
    localparam int PW      = 2 * VEL_BITS + 1;
    localparam int PRW     = XW + cvr_pkg::GAIN_W;
    localparam int RW      = PRW - cvr_pkg::ROUND_SHIFT;
    localparam int ZW      = cvr_pkg::Z_W;
    localparam int NS      = cvr_pkg::NUM_STAGES;
    localparam int NC      = cvr_pkg::CORDIC_ITERS;

    localparam longint VMAX_L = (64'sd1 <<< (VEL_BITS - 1)) - 64'sd1;
    localparam logic signed [RW-1:0]       VMAX_R = RW'(VMAX_L);
    localparam logic signed [RW-1:0]       VMIN_R = RW'(-VMAX_L - 64'sd1);
    localparam logic signed [VEL_BITS-1:0] VMAX_V = VEL_BITS'(VMAX_L);
    localparam logic signed [VEL_BITS-1:0] VMIN_V = VEL_BITS'(-VMAX_L - 64'sd1);
    localparam logic signed [PRW-1:0]      RND    =
        PRW'(64'sd1 <<< (cvr_pkg::ROUND_SHIFT - 1));

    // ---------------- configuration registers ----------------
    logic [cvr_pkg::CFG_DATA_W-1:0] r_zero_offset;
    cvr_pkg::t_drive_mode           r_drive_mode;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_offset <= '0;
            r_drive_mode  <= cvr_pkg::MODE_GIMBAL_FOLLOW;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cvr_pkg::REG_ZERO_OFFSET: begin
                    r_zero_offset <= i_cfg_data;
                end
                cvr_pkg::REG_DRIVE_MODE: begin
                    if (i_cfg_data[1:0] != cvr_pkg::MODE_RESERVED) begin
                        r_drive_mode <= cvr_pkg::t_drive_mode'(i_cfg_data[1:0]);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- stage advance chain ----------------
    // A stage moves when it is empty or the stage after it moves.
    logic [NS-1:0] w_v;
    logic [NS-1:0] w_en;
    logic          r_out_valid;

    always_comb begin
        w_en[NS-1] = !w_v[NS-1] || i_m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !w_v[k] || w_en[k+1];
        end
    end

    assign o_s_axis_tready = w_en[0];
    assign w_v[NS-1]       = r_out_valid;

    // ---------------- front stage ----------------
    logic [ANGLE_BITS-1:0]       w_angle, w_rel;
    logic signed [VEL_BITS-1:0]  w_vx, w_vy, w_w;
    logic [ZW-1:0]               w_bang, w_resid;
    logic [1:0]                  w_quad;
    logic signed [XW-1:0]        w_vx_e, w_vy_e, w_xq, w_yq;
    logic signed [VEL_BITS-1:0]  w_rate_tgt;
    logic                        w_tsat;

    assign w_angle = i_s_axis_tdata[ANGLE_BITS-1:0];
    assign w_vx    = $signed(i_s_axis_tdata[ANGLE_BITS +: VEL_BITS]);
    assign w_vy    = $signed(i_s_axis_tdata[ANGLE_BITS + VEL_BITS +: VEL_BITS]);
    assign w_w     = $signed(i_s_axis_tdata[ANGLE_BITS + 2 * VEL_BITS +: VEL_BITS]);

    always_comb begin
        // relative angle, widened to a full-scale binary angle
        w_rel   = w_angle - ANGLE_BITS'(r_zero_offset);
        w_bang  = {w_rel, {(ZW - ANGLE_BITS){1'b0}}};
        // nearest quadrant and the residual around it
        w_quad  = w_bang[ZW-1:ZW-2] + {1'b0, w_bang[ZW-3]};
        w_resid = w_bang - {w_quad, {(ZW - 2){1'b0}}};
        // exact 90 degree pre-rotation
        w_vx_e  = XW'(w_vx);
        w_vy_e  = XW'(w_vy);
        case (w_quad)
            2'd1: begin
                w_xq = -w_vy_e;
                w_yq = w_vx_e;
            end
            2'd2: begin
                w_xq = -w_vx_e;
                w_yq = -w_vy_e;
            end
            2'd3: begin
                w_xq = w_vy_e;
                w_yq = -w_vx_e;
            end
            default: begin
                w_xq = w_vx_e;
                w_yq = w_vy_e;
            end
        endcase
        // relative-rate target, negation clips at the most negative rate
        w_rate_tgt = '0;
        w_tsat     = 1'b0;
        if (r_drive_mode != cvr_pkg::MODE_GIMBAL_FOLLOW) begin
            if (w_w == VMIN_V) begin
                w_rate_tgt = VMAX_V;
                w_tsat     = 1'b1;
            end else begin
                w_rate_tgt = -w_w;
            end
        end
    end

    logic                     r_v0;
    logic signed [XW-1:0]     r_x0, r_y0;
    logic signed [ZW-1:0]     r_z0;
    logic [PW-1:0]            r_pass0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en[0]) begin
            r_v0 <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_x0    <= w_xq <<< cvr_pkg::GUARD_BITS;
            r_y0    <= w_yq <<< cvr_pkg::GUARD_BITS;
            r_z0    <= $signed(w_resid);
            r_pass0 <= {w_tsat, w_rate_tgt, w_w};
        end
    end

    assign w_v[0] = r_v0;

    // ---------------- CORDIC cell chain ----------------
    logic signed [XW-1:0] w_cx [NC+1];
    logic signed [XW-1:0] w_cy [NC+1];
    logic signed [ZW-1:0] w_cz [NC+1];
    logic [PW-1:0]        w_cp [NC+1];

    assign w_cx[0] = r_x0;
    assign w_cy[0] = r_y0;
    assign w_cz[0] = r_z0;
    assign w_cp[0] = r_pass0;

    for (genvar g = 0; g < NC; g++) begin : g_cell
        cvr_cordic_cell #(
            .XW    (XW),
            .PW    (PW),
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en[g+1]),
            .i_valid (w_v[g]),
            .i_x     (w_cx[g]),
            .i_y     (w_cy[g]),
            .i_z     (w_cz[g]),
            .i_pass  (w_cp[g]),
            .o_valid (w_v[g+1]),
            .o_x     (w_cx[g+1]),
            .o_y     (w_cy[g+1]),
            .o_z     (w_cz[g+1]),
            .o_pass  (w_cp[g+1])
        );
    end

    // ---------------- gain multiply ----------------
    logic signed [PRW-1:0] w_px, w_py;
    logic [PW-1:0]         w_mpass;

    cvr_gain_mult #(
        .XW  (XW),
        .PW  (PW),
        .PRW (PRW)
    ) u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en[NC+1]),
        .i_valid (w_v[NC]),
        .i_x     (w_cx[NC]),
        .i_y     (w_cy[NC]),
        .i_pass  (w_cp[NC]),
        .o_valid (w_v[NC+1]),
        .o_px    (w_px),
        .o_py    (w_py),
        .o_pass  (w_mpass)
    );

    // ---------------- round, saturate, output register ----------------
    logic signed [PRW-1:0]      w_sx, w_sy;
    logic signed [RW-1:0]       w_rx, w_ry;
    logic signed [VEL_BITS-1:0] w_ox, w_oy;
    logic                       w_xsat, w_ysat;

    always_comb begin
        w_sx = (w_px + RND) >>> cvr_pkg::ROUND_SHIFT;
        w_sy = (w_py + RND) >>> cvr_pkg::ROUND_SHIFT;
        w_rx = w_sx[RW-1:0];
        w_ry = w_sy[RW-1:0];
        w_xsat = 1'b1;
        w_ysat = 1'b1;
        if (w_rx > VMAX_R) begin
            w_ox = VMAX_V;
        end else if (w_rx < VMIN_R) begin
            w_ox = VMIN_V;
        end else begin
            w_ox   = w_rx[VEL_BITS-1:0];
            w_xsat = 1'b0;
        end
        if (w_ry > VMAX_R) begin
            w_oy = VMAX_V;
        end else if (w_ry < VMIN_R) begin
            w_oy = VMIN_V;
        end else begin
            w_oy   = w_ry[VEL_BITS-1:0];
            w_ysat = 1'b0;
        end
    end

    logic [VEL_BITS-1:0] r_out_x, r_out_y, r_out_w, r_out_t;
    logic                r_out_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en[NS-1]) begin
            r_out_valid <= w_v[NS-2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NS-1]) begin
            r_out_x   <= w_ox;
            r_out_y   <= w_oy;
            r_out_w   <= w_mpass[VEL_BITS-1:0];
            r_out_t   <= w_mpass[2*VEL_BITS-1:VEL_BITS];
            r_out_sat <= w_xsat || w_ysat || w_mpass[2*VEL_BITS];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDW'({r_out_t, r_out_w, r_out_y, r_out_x});
    assign o_m_axis_tuser  = r_out_sat;

    // ---------------- assertions ----------------
    // input backpressure only ever comes from a stalled output
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled without an output stall");

    // an accepted word always lands in the front stage
    a_front_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> w_v[0])
        else $error("accepted word lost at front stage");

    // a taken word with nothing behind it leaves the output empty
    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && !w_v[NS-2]) |=> !o_m_axis_tvalid)
        else $error("output word repeated");

    // the flag is set only if some output sits at a rail
    a_sat_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_out_t == '0
            && $signed(r_out_x) != VMAX_V && $signed(r_out_x) != VMIN_V
            && $signed(r_out_y) != VMAX_V && $signed(r_out_y) != VMIN_V)
        |-> !o_m_axis_tuser)
        else $error("saturated flag without a clipped output");

endmodule
